FILE: rtl/tlpm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpm_pkg
// Shared constants and controller/datapath interface types for the page map.
// ---------------------------------------------------------------------------
package tlpm_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_SLOTS   = 16;

  localparam int IDX_W   = 10;   // directory / table index width
  localparam int DIR_SHIFT = 22;
  localparam int TAB_SHIFT = 12;
  localparam int OFFS_W  = 12;
  localparam int FRAME_W = 20;
  localparam int PTE_W   = FRAME_W + 3;

  localparam int F_PRESENT = 0;
  localparam int F_WRITE   = 1;
  localparam int F_USER    = 2;

  localparam logic MODE_MAP   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  localparam logic REG_WIN_LOW  = 1'b0;
  localparam logic REG_WIN_HIGH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted item
    logic win;        // latch first/last page of the range
    logic dir_clr;    // clear one directory entry (reset sweep)
    logic clr_step;
    logic dir_alloc;  // write a fresh directory entry, take a slot
    logic take_slot;  // slot comes from the directory entry just read
    logic pool_clr;   // zero one entry of the new slot
    logic pool_wr;    // write the page entry
    logic pool_rd;
    logic page_step;
    logic res_load;
    logic res_fail;
    logic res_flush;
  } tlpm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic map_bad;
    logic dir_present;
    logic slots_full;
    logic user_conflict;
    logic len_zero;
    logic win_fail;
    logic pde_ok;
    logic pte_ok;
    logic page_last;
    logic sweep_last;
    logic out_free;
  } tlpm_sts_t;

endpackage

FILE: rtl/tlpm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpm_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tlpm_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpm_dpath
// Item registers, directory and table pool memories, range compare and the
// result register.
// ---------------------------------------------------------------------------
module tlpm_dpath
  import tlpm_pkg::*;
#(
  parameter int SLOTS = TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tlpm_cmd_t   cmd,
  output tlpm_sts_t   sts,
  input  logic        in_mode,
  input  logic [31:0] in_virt_addr,
  input  logic [31:0] in_frame_addr,
  input  logic [31:0] in_map_flags,
  input  logic [31:0] in_range_length,
  input  logic        in_want_write,
  input  logic [31:0] win_low,
  input  logic [31:0] win_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic        out_flush_valid,
  output logic [31:0] out_flush_addr
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int DIR_W   = SLOT_W + 3;
  localparam int POOL_D  = SLOTS * TABLE_ENTRIES;
  localparam int POOL_AW = $clog2(POOL_D);

  logic              mode_r, wr_r;
  logic [31:0]       va_r, pa_r, fl_r, len_r;
  logic [FRAME_W-1:0] page_r, last_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  free_r;
  logic [IDX_W-1:0]  clr_r, sweep_r;
  logic              out_valid_r, out_status_r, out_flush_r;
  logic [31:0]       out_addr_r;

  logic              dir_we, pool_we;
  logic [IDX_W-1:0]  dir_addr;
  logic [DIR_W-1:0]  dir_wdata, dir_q;
  logic [POOL_AW-1:0] pool_addr;
  logic [PTE_W-1:0]  pool_wdata, pte_q;
  logic [SLOT_W-1:0] dir_slot;
  logic [31:0]       range_end;

  assign dir_slot  = dir_q[DIR_W-1:3];
  assign range_end = va_r + len_r - 32'd1;

  // directory port
  always_comb begin
    if (cmd.dir_clr) begin
      dir_addr = clr_r;
    end else if (mode_r == MODE_MAP) begin
      dir_addr = va_r[31:DIR_SHIFT];
    end else begin
      dir_addr = page_r[FRAME_W-1:IDX_W];
    end
  end
  assign dir_we    = cmd.dir_clr | cmd.dir_alloc;
  assign dir_wdata = cmd.dir_clr ? '0 :
                     {SLOT_W'(free_r), fl_r[F_USER], 1'b1, 1'b1};

  // pool port
  always_comb begin
    if (cmd.pool_rd) begin
      pool_addr = POOL_AW'({dir_slot, page_r[IDX_W-1:0]});
    end else if (cmd.pool_clr) begin
      pool_addr = POOL_AW'({slot_r, sweep_r});
    end else begin
      pool_addr = POOL_AW'({slot_r, va_r[DIR_SHIFT-1:TAB_SHIFT]});
    end
  end
  assign pool_we    = cmd.pool_clr | cmd.pool_wr;
  assign pool_wdata = cmd.pool_clr ? '0 :
                      {pa_r[31:OFFS_W], fl_r[F_USER], fl_r[F_WRITE], 1'b1};

  tlpm_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_q)
  );

  tlpm_ram #(.WIDTH(PTE_W), .DEPTH(POOL_D)) u_pool (
    .clk(clk), .we(pool_we), .addr(pool_addr), .wdata(pool_wdata), .rdata(pte_q)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      va_r   <= in_virt_addr;
      pa_r   <= in_frame_addr;
      fl_r   <= in_map_flags;
      len_r  <= in_range_length;
      wr_r   <= in_want_write;
    end
    if (cmd.win) begin
      page_r <= va_r[31:OFFS_W];
      last_r <= range_end[31:OFFS_W];
    end else if (cmd.page_step) begin
      page_r <= page_r + FRAME_W'(1);
    end
    if (cmd.dir_alloc) begin
      slot_r <= SLOT_W'(free_r);
    end else if (cmd.take_slot) begin
      slot_r <= dir_slot;
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_fail;
      out_flush_r  <= cmd.res_flush;
      out_addr_r   <= cmd.res_flush ? va_r : 32'd0;
    end
  end

  // control counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      clr_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.dir_alloc) begin
        free_r  <= free_r + CNT_W'(1);
        sweep_r <= '0;
      end else if (cmd.pool_clr) begin
        sweep_r <= sweep_r + IDX_W'(1);
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last      = (clr_r == IDX_W'(DIR_ENTRIES - 1));
    sts.map_bad       = (va_r[OFFS_W-1:0] != '0) || (pa_r[OFFS_W-1:0] != '0) ||
                        (fl_r[31:3] != '0);
    sts.dir_present   = dir_q[F_PRESENT];
    sts.slots_full    = (free_r == CNT_W'(SLOTS));
    sts.user_conflict = fl_r[F_USER] && !dir_q[F_USER];
    sts.len_zero      = (len_r == 32'd0);
    sts.win_fail      = (va_r < win_low) || (va_r >= win_high) ||
                        (len_r > (win_high - va_r));
    sts.pde_ok        = dir_q[F_PRESENT] && dir_q[F_USER] && (!wr_r || dir_q[F_WRITE]);
    sts.pte_ok        = pte_q[F_PRESENT] && pte_q[F_USER] && (!wr_r || pte_q[F_WRITE]);
    sts.page_last     = (page_r == last_r);
    sts.sweep_last    = (sweep_r == IDX_W'(TABLE_ENTRIES - 1));
    sts.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_flush_valid = out_flush_r;
  assign out_flush_addr  = out_addr_r;

endmodule

FILE: rtl/tlpm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpm_ctrl
// Sequencer: directory clear after reset, map and range-check walks.
// ---------------------------------------------------------------------------
module tlpm_ctrl
  import tlpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  tlpm_sts_t sts,
  output tlpm_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAP_RD, S_MAP_DEC, S_MAP_CLR, S_MAP_WR,
    S_CHK_WIN, S_CHK_DIR, S_CHK_PDE, S_CHK_PTE, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   fail_r, fail_nxt, flush_r, flush_nxt;

  always_comb begin
    state_nxt = state_r;
    fail_nxt  = fail_r;
    flush_nxt = flush_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.dir_clr  = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          fail_nxt  = 1'b0;
          flush_nxt = 1'b0;
          state_nxt = (in_mode == MODE_MAP) ? S_MAP_RD : S_CHK_WIN;
        end
      end
      S_MAP_RD: begin
        // directory address is presented here, data arrives next cycle
        state_nxt = S_MAP_DEC;
      end
      S_MAP_DEC: begin
        if (sts.map_bad) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (!sts.dir_present) begin
          if (sts.slots_full) begin
            fail_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else begin
            cmd.dir_alloc = 1'b1;
            state_nxt     = S_MAP_CLR;
          end
        end else if (sts.user_conflict) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.take_slot = 1'b1;
          state_nxt     = S_MAP_WR;
        end
      end
      S_MAP_CLR: begin
        cmd.pool_clr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_MAP_WR;
        end
      end
      S_MAP_WR: begin
        cmd.pool_wr = 1'b1;
        flush_nxt   = 1'b1;
        state_nxt   = S_FIN;
      end
      S_CHK_WIN: begin
        cmd.win = 1'b1;
        if (sts.len_zero) begin
          state_nxt = S_FIN;
        end else if (sts.win_fail) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK_DIR;
        end
      end
      S_CHK_DIR: begin
        state_nxt = S_CHK_PDE;
      end
      S_CHK_PDE: begin
        if (!sts.pde_ok) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.pool_rd = 1'b1;
          state_nxt   = S_CHK_PTE;
        end
      end
      S_CHK_PTE: begin
        if (!sts.pte_ok) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.page_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.page_step = 1'b1;
          state_nxt     = S_CHK_DIR;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load  = 1'b1;
          cmd.res_fail  = fail_r;
          cmd.res_flush = flush_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      fail_r  <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fail_r  <= fail_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

FILE: rtl/two_level_page_map_and_range_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_page_map_and_range_check
// Two-level page table with single-page map and user range access check.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+-------------------
//  input    | in_valid/in_ready, in_* fields            | valid & ready
//  result   | out_valid/out_ready, out_* fields         | valid & ready
//  config   | psel/penable/pwrite/paddr/pwdata/prdata   | access phase write
//
//  After reset the directory is swept clear; no item is taken until then. A
//  map reads the directory entry, sweeps a new table slot clear when it
//  allocates one, and writes the page entry. A check tests the range against
//  the window, then reads the directory and table entries of each page on the
//  single-port memories; the walk stops at the first failing page. One item
//  is in flight; the next is taken while the last result waits at the output.
// ---------------------------------------------------------------------------
module two_level_page_map_and_range_check
  import tlpm_pkg::*;
#(
  parameter int SLOTS = TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_virt_addr,
  input  logic [31:0] in_frame_addr,
  input  logic [31:0] in_map_flags,
  input  logic [31:0] in_range_length,
  input  logic        in_want_write,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic        out_flush_valid,
  output logic [31:0] out_flush_addr,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlpm_cmd_t   cmd;
  tlpm_sts_t   sts;
  logic [31:0] win_low_r, win_high_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_WIN_HIGH) ? win_high_r : win_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= 32'h0040_0000;
      win_high_r <= 32'hC000_0000;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIN_HIGH) begin
        win_high_r <= pwdata;
      end else begin
        win_low_r <= pwdata;
      end
    end
  end

  tlpm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_mode(in_mode),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  tlpm_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_virt_addr(in_virt_addr), .in_frame_addr(in_frame_addr),
    .in_map_flags(in_map_flags), .in_range_length(in_range_length),
    .in_want_write(in_want_write), .win_low(win_low_r), .win_high(win_high_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_flush_valid(out_flush_valid), .out_flush_addr(out_flush_addr)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level page map: directed and random map and
// range check items under random idling on both channels, window registers
// changed between phases, every result compared against a page table shadow.
// ---------------------------------------------------------------------------
import tlpm_pkg::*;

typedef struct {
  logic        mode;
  logic [31:0] virt_addr;
  logic [31:0] frame_addr;
  logic [31:0] map_flags;
  logic [31:0] range_length;
  logic        want_write;
} pm_item_t;

typedef struct {
  logic        status;
  logic        flush_valid;
  logic [31:0] flush_addr;
} pm_resp_t;

class page_table_sb;
  logic             dir_p [DIR_ENTRIES];
  logic             dir_w [DIR_ENTRIES];
  logic             dir_u [DIR_ENTRIES];
  int unsigned      dir_slot [DIR_ENTRIES];
  logic [PTE_W-1:0] pte_store [int unsigned];
  int unsigned      slots_taken;
  logic [31:0]      win_lo;
  logic [31:0]      win_hi;
  pm_resp_t         pending [$];
  int               errors;

  function new();
    foreach (dir_p[i]) begin
      dir_p[i] = 1'b0;
      dir_w[i] = 1'b0;
      dir_u[i] = 1'b0;
      dir_slot[i] = 0;
    end
    slots_taken = 0;
    win_lo = 32'h0040_0000;
    win_hi = 32'hC000_0000;
    errors = 0;
  endfunction

  function void set_window(logic idx, logic [31:0] val);
    if (idx == REG_WIN_LOW) win_lo = val;
    else win_hi = val;
  endfunction

  function bit install_page(logic [31:0] va, logic [31:0] pa, logic [31:0] fl);
    int unsigned di, ti, s;
    di = va[31:22];
    ti = va[21:12];
    if (va[11:0] != 0 || pa[11:0] != 0) return 0;
    if ((fl & ~32'h7) != 0) return 0;
    if (!dir_p[di]) begin
      if (slots_taken >= TABLE_SLOTS) return 0;
      s = slots_taken;
      slots_taken++;
      for (int e = 0; e < TABLE_ENTRIES; e++) pte_store.delete(s * TABLE_ENTRIES + e);
      dir_slot[di] = s;
      dir_p[di] = 1'b1;
      dir_w[di] = 1'b1;
      dir_u[di] = fl[F_USER];
    end else if (fl[F_USER] && !dir_u[di]) begin
      return 0;
    end
    pte_store[dir_slot[di] * TABLE_ENTRIES + ti] = {pa[31:12], fl[F_USER], fl[F_WRITE], 1'b1};
    return 1;
  endfunction

  function bit page_allowed(logic [31:0] va, logic wr);
    int unsigned di, key;
    logic [PTE_W-1:0] pte;
    di = va[31:22];
    if (!dir_p[di] || !dir_u[di]) return 0;
    if (wr && !dir_w[di]) return 0;
    key = dir_slot[di] * TABLE_ENTRIES + va[21:12];
    pte = pte_store.exists(key) ? pte_store[key] : '0;
    if (!pte[F_PRESENT] || !pte[F_USER]) return 0;
    if (wr && !pte[F_WRITE]) return 0;
    return 1;
  endfunction

  function bit range_allowed(logic [31:0] va, logic [31:0] len, logic wr);
    logic [31:0] page, last;
    if (len == 0) return 1;
    if (va < win_lo || va >= win_hi || len > win_hi - va) return 0;
    page = va & 32'hFFFF_F000;
    last = (va + len - 32'd1) & 32'hFFFF_F000;
    forever begin
      if (!page_allowed(page, wr)) return 0;
      if (page == last) return 1;
      page = page + 32'h1000;
    end
  endfunction

  function void note_input(pm_item_t it);
    pm_resp_t r;
    r.flush_valid = 1'b0;
    r.flush_addr = '0;
    if (it.mode == MODE_MAP) begin
      r.status = !install_page(it.virt_addr, it.frame_addr, it.map_flags);
      if (!r.status) begin
        r.flush_valid = 1'b1;
        r.flush_addr = it.virt_addr;
      end
    end else begin
      r.status = !range_allowed(it.virt_addr, it.range_length, it.want_write);
    end
    pending.push_back(r);
  endfunction

  function void check_result(pm_resp_t got);
    pm_resp_t exp_r;
    if (pending.size() == 0) begin
      $error("result with nothing outstanding: status=%0d", got.status);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.flush_valid !== exp_r.flush_valid) begin
      $error("flush_valid: expected %0d, got %0d", exp_r.flush_valid, got.flush_valid);
      errors++;
    end
    if (got.flush_addr !== exp_r.flush_addr) begin
      $error("flush_addr: expected %h, got %h", exp_r.flush_addr, got.flush_addr);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [31:0] in_virt_addr = '0;
  logic [31:0] in_frame_addr = '0;
  logic [31:0] in_map_flags = '0;
  logic [31:0] in_range_length = '0;
  logic        in_want_write = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic        out_flush_valid;
  logic [31:0] out_flush_addr;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  page_table_sb sb = new();
  int  sent;
  bit  hold_req;
  bit  hold_done;
  int  idle_cnt;

  two_level_page_map_and_range_check i_dut (.*);

  always #5 clk = ~clk;

  // output side: random stalls, one long hold-off, a calm stretch
  initial begin
    int k;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (k = 0; k < 400; k++) @(negedge clk);
        hold_done = 1'b1;
      end
      if (sent > 700 && sent < 1000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    pm_resp_t r;
    if (rst_n && out_valid && out_ready) begin
      r.status = out_status;
      r.flush_valid = out_flush_valid;
      r.flush_addr = out_flush_addr;
      sb.check_result(r);
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 200000) begin
      $display("two_level_page_map_and_range_check regression: fail");
      $finish;
    end
  end

  task automatic push_item(pm_item_t it);
    @(negedge clk);
    while (!(sent > 600 && sent < 900) && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_virt_addr <= it.virt_addr;
    in_frame_addr <= it.frame_addr;
    in_map_flags <= it.map_flags;
    in_range_length <= it.range_length;
    in_want_write <= it.want_write;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_window(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic pm_item_t mk(logic m, logic [31:0] va, logic [31:0] pa,
                                  logic [31:0] fl, logic [31:0] len, logic wr);
    pm_item_t it;
    it.mode = m;
    it.virt_addr = va;
    it.frame_addr = pa;
    it.map_flags = fl;
    it.range_length = len;
    it.want_write = wr;
    return it;
  endfunction

  function automatic pm_item_t rand_item(int unsigned dir_lo, int unsigned dir_n);
    pm_item_t it;
    int unsigned roll;
    logic [31:0] page;
    it = mk(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
            1'($urandom_range(1)));
    page = {10'(dir_lo + $urandom_range(dir_n - 1)), 10'($urandom_range(15)), 12'h000};
    roll = $urandom_range(99);
    if (roll < 35) begin
      it.mode = MODE_MAP;
      it.virt_addr = page;
      it.frame_addr[11:0] = '0;
      it.map_flags = $urandom_range(7);
    end else if (roll < 43) begin
      it.mode = MODE_MAP;
      if ($urandom_range(1)) it.virt_addr = page;
    end else if (roll < 85) begin
      it.mode = MODE_CHECK;
      it.virt_addr = page | $urandom_range(32'hFFF);
      case ($urandom_range(3))
        0: it.range_length = 0;
        1: it.range_length = $urandom_range(1, 32'h1000);
        2: it.range_length = $urandom_range(1, 32'h3000);
        default: it.range_length = $urandom_range(1, 32'h10000);
      endcase
    end else begin
      it.mode = MODE_CHECK;
    end
    return it;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_WIN_LOW, 32'h0040_0000);
    write_reg(REG_WIN_HIGH, 32'hC000_0000);

    // directed
    push_item(mk(MODE_MAP, 32'h0040_0800, 32'h0000_1000, 32'h7, 0, 0));
    push_item(mk(MODE_MAP, 32'h0040_0000, 32'h0000_1004, 32'h7, 0, 0));
    push_item(mk(MODE_MAP, 32'h0040_0000, 32'h0000_1000, 32'hFFFF_FFF8, 0, 0));
    push_item(mk(MODE_MAP, 32'h0040_0000, 32'hFFFF_F000, 32'h7, 0, 0));
    push_item(mk(MODE_MAP, 32'h0040_1000, 32'h0000_2000, 32'h4, 0, 0));
    push_item(mk(MODE_MAP, 32'h0080_0000, 32'h0000_3000, 32'h3, 0, 0));
    push_item(mk(MODE_MAP, 32'h0080_1000, 32'h0000_4000, 32'h7, 0, 0));
    push_item(mk(MODE_MAP, 32'h0080_2000, 32'h0000_5000, 32'h0, 0, 0));
    push_item(mk(MODE_CHECK, 32'h0000_0000, 0, 0, 32'h0, 1));
    push_item(mk(MODE_CHECK, 32'h003F_FFFF, 0, 0, 32'h1, 0));
    push_item(mk(MODE_CHECK, 32'hC000_0000, 0, 0, 32'h1, 0));
    push_item(mk(MODE_CHECK, 32'hBFFF_FFFF, 0, 0, 32'h2, 0));
    push_item(mk(MODE_CHECK, 32'h0040_0010, 0, 0, 32'h100, 1));
    push_item(mk(MODE_CHECK, 32'h0040_0FFF, 0, 0, 32'h2, 1));
    push_item(mk(MODE_CHECK, 32'h0040_0FFF, 0, 0, 32'h2, 0));
    push_item(mk(MODE_CHECK, 32'h0040_0000, 0, 0, 32'hFFFF_FFFF, 0));
    push_item(mk(MODE_CHECK, 32'h0080_0000, 0, 0, 32'h10, 0));
    push_item(mk(MODE_CHECK, 32'h0040_2000, 0, 0, 32'h10, 0));
    push_item(mk(MODE_CHECK, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1));

    for (int i = 0; i < 700; i++) begin
      if (i == 300) hold_req = 1'b1;
      push_item(rand_item(1, 24));
    end
    drain();

    write_reg(REG_WIN_LOW, 32'h0000_0000);
    write_reg(REG_WIN_HIGH, 32'hFFFF_FFFF);
    for (int i = 0; i < 450; i++) push_item(rand_item(0, 28));
    drain();

    write_reg(REG_WIN_LOW, 32'hFFFF_FFFF);
    write_reg(REG_WIN_HIGH, 32'h0000_0000);
    for (int i = 0; i < 150; i++) push_item(rand_item(1, 24));
    drain();

    write_reg(REG_WIN_LOW, 32'h0080_0000);
    write_reg(REG_WIN_HIGH, 32'h0140_0000);
    for (int i = 0; i < 330; i++) push_item(rand_item(1, 6));
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("two_level_page_map_and_range_check regression: pass");
    else
      $display("two_level_page_map_and_range_check regression: fail");
    $finish;
  end
endmodule

FILE: two_level_page_map_and_range_check.f
rtl/tlpm_pkg.sv
rtl/tlpm_ram.sv
rtl/tlpm_dpath.sv
rtl/tlpm_ctrl.sv
rtl/two_level_page_map_and_range_check.sv
tb/sv/testbench.sv
